/* rtl/core/bond_percolation_union_find_unit_defines.svh */
// Assertion macros used by the union-find unit RTL (bpuf_ctrl).
// Users must have signals named clock and reset in scope.
`ifndef BOND_PERCOLATION_UNION_FIND_UNIT_DEFINES_SVH
`define BOND_PERCOLATION_UNION_FIND_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BPUF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BPUF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/bpuf_pkg.sv */
// Shared types and constants for the union-find unit.
// No dependencies; every other file but the assertion macro header depends on it.
`default_nettype none

package bpuf_pkg;

   localparam int DEF_MAX_NODES = 1024;
   localparam int COUNT_W       = 11;
   localparam int NODE_W        = 10;
   localparam int CSR_ADDR_W    = 2;

   localparam logic CMD_RESTART = 1'b0;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_MAIN_COUNT,
      REG_TOTAL_COUNT,
      REG_BOUNDARY_A,
      REG_BOUNDARY_B
   } reg_index_type;

   typedef enum logic [1:0] {
      SEL_U,
      SEL_V,
      SEL_A,
      SEL_B
   } node_sel_type;

   typedef enum logic {
      FOREST_SPAN,
      FOREST_MAIN
   } forest_type;

   typedef struct packed {
      logic         clr_en;
      logic         ld_req;
      logic         ld_node;
      node_sel_type node_sel;
      forest_type   forest;
      logic         rd;
      logic         step;
      logic         save_a;
      logic         save_b;
      logic         join_root;
      logic         join_link;
      logic         mark_span;
      logic         restart;
      logic         ld_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_restart;
      logic edge_ok;
      logic span_go;
      logic main_ok;
      logic root_found;
      logic roots_eq;
   } dp_status_type;

endpackage

`default_nettype wire

/* rtl/core/bpuf_ifs.sv */
// Channel interfaces of the union-find unit: request, response and register write.
// Depends on bpuf_pkg for field widths.
`default_nettype none

interface bpuf_req_if;
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic [bpuf_pkg::NODE_W-1:0]   node_u;
   logic [bpuf_pkg::NODE_W-1:0]   node_v;
   modport source (output valid, cmd, node_u, node_v, input ready);
   modport sink   (input valid, cmd, node_u, node_v, output ready);
endinterface

interface bpuf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bpuf_pkg::COUNT_W-1:0]  largest_cluster;
   logic                          spanning;
   modport source (output valid, largest_cluster, spanning, input ready);
   modport sink   (input valid, largest_cluster, spanning, output ready);
endinterface

interface bpuf_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bpuf_pkg::CSR_ADDR_W-1:0] addr;
   logic [bpuf_pkg::COUNT_W-1:0]    data;
   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/bpuf_datapath.sv */
// Datapath of the union-find unit: both forest memories, root walker registers,
// join logic, configuration registers and result registers. Depends on bpuf_pkg.
`default_nettype none

module bpuf_datapath #(
   parameter int MAX_NODES = bpuf_pkg::DEF_MAX_NODES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bpuf_pkg::ctrl_cmd_type            cmd,
   output bpuf_pkg::dp_status_type           stat,
   input  logic                              csr_we,
   input  logic [bpuf_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [bpuf_pkg::COUNT_W-1:0]      csr_data,
   input  logic                              req_cmd,
   input  logic [bpuf_pkg::NODE_W-1:0]       req_node_u,
   input  logic [bpuf_pkg::NODE_W-1:0]       req_node_v,
   output logic [bpuf_pkg::COUNT_W-1:0]      largest_cluster,
   output logic                              spanning
);
   import bpuf_pkg::*;

   localparam int AW = $clog2(MAX_NODES);
   localparam int EW = AW + 2;
   localparam int CW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
   localparam logic [CW-1:0] MAX_C    = CW'(MAX_NODES);
   localparam logic [AW-1:0] LAST_IDX = AW'(MAX_NODES - 1);

   logic [COUNT_W-1:0]        main_count_ff, total_count_ff;
   logic signed [COUNT_W-1:0] bound_a_ff, bound_b_ff;
   logic                      item_cmd_ff;
   logic [NODE_W-1:0]         u_ff, v_ff;
   logic [AW-1:0]             node_ff, node_src, clr_ff;
   logic [AW-1:0]             ra_ff, rb_ff, winner, loser;
   logic signed [EW-1:0]      va_ff, vb_ff, sum_val, neg_sum, rdata;
   logic signed [EW-1:0]      span_rd_ff, main_rd_ff, wr_data;
   logic [AW-1:0]             wr_addr;
   logic                      span_we, main_we;
   logic [CW-1:0]             mains_ext, total_ext, mains_c, total_c;
   logic [CW-1:0]             u_ext, v_ext, a_ext, b_ext, join_size, largest_ff;
   logic                      span_ff, span_on, a_wins;
   logic [COUNT_W-1:0]        lc_ff;
   logic                      sp_ff;

   logic signed [EW-1:0] span_mem [MAX_NODES];
   logic signed [EW-1:0] main_mem [MAX_NODES];

   always_ff @(posedge clock) begin
      if (reset) begin
         main_count_ff  <= '0;
         total_count_ff <= '0;
         bound_a_ff     <= '1;
         bound_b_ff     <= '1;
      end else if (csr_we) begin
         case (reg_index_type'(csr_addr))
            REG_MAIN_COUNT:  main_count_ff  <= csr_data;
            REG_TOTAL_COUNT: total_count_ff <= csr_data;
            REG_BOUNDARY_A:  bound_a_ff     <= csr_data;
            REG_BOUNDARY_B:  bound_b_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_req) begin
         item_cmd_ff <= req_cmd;
         u_ff        <= req_node_u;
         v_ff        <= req_node_v;
      end
   end

   // Counts are clamped to the forest depth.
   always_comb begin
      mains_ext = CW'(main_count_ff);
      total_ext = CW'(total_count_ff);
      mains_c   = (mains_ext > MAX_C) ? MAX_C : mains_ext;
      total_c   = (total_ext > MAX_C) ? MAX_C : total_ext;
      u_ext     = CW'(u_ff);
      v_ext     = CW'(v_ff);
      a_ext     = CW'(unsigned'(bound_a_ff));
      b_ext     = CW'(unsigned'(bound_b_ff));
      span_on   = !bound_a_ff[COUNT_W-1] && !bound_b_ff[COUNT_W-1] &&
                  (a_ext < total_c) && (b_ext < total_c);
   end

   always_comb begin
      case (cmd.node_sel)
         SEL_U:   node_src = u_ext[AW-1:0];
         SEL_V:   node_src = v_ext[AW-1:0];
         SEL_A:   node_src = a_ext[AW-1:0];
         SEL_B:   node_src = b_ext[AW-1:0];
         default: node_src = u_ext[AW-1:0];
      endcase
   end

   assign rdata = (cmd.forest == FOREST_MAIN) ? main_rd_ff : span_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.ld_node) begin
         node_ff <= node_src;
      end else if (cmd.step) begin
         node_ff <= rdata[AW-1:0];
      end
      if (cmd.save_a) begin
         ra_ff <= node_ff;
         va_ff <= rdata;
      end
      if (cmd.save_b) begin
         rb_ff <= node_ff;
         vb_ff <= rdata;
      end
   end

   // Union by size: the root with the larger cluster (more negative entry) wins; ties go to a.
   always_comb begin
      a_wins    = !(va_ff > vb_ff);
      winner    = a_wins ? ra_ff : rb_ff;
      loser     = a_wins ? rb_ff : ra_ff;
      sum_val   = va_ff + vb_ff;
      neg_sum   = -sum_val;
      join_size = CW'(neg_sum[AW:0]);
   end

   always_comb begin
      wr_addr = clr_ff;
      wr_data = '1;
      span_we = 1'b0;
      main_we = 1'b0;
      if (cmd.clr_en) begin
         span_we = 1'b1;
         main_we = 1'b1;
      end else if (cmd.join_root || cmd.join_link) begin
         wr_addr = cmd.join_root ? winner : loser;
         wr_data = cmd.join_root ? sum_val : EW'(winner);
         span_we = (cmd.forest == FOREST_SPAN);
         main_we = (cmd.forest == FOREST_MAIN);
      end
   end

   always_ff @(posedge clock) begin
      if (span_we) begin
         span_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd) begin
         span_rd_ff <= span_mem[node_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (main_we) begin
         main_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd) begin
         main_rd_ff <= main_mem[node_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= '0;
         largest_ff <= '0;
         span_ff    <= 1'b0;
      end else begin
         if (cmd.clr_en) begin
            clr_ff <= (clr_ff == LAST_IDX) ? '0 : clr_ff + 1'b1;
         end
         if (cmd.restart) begin
            largest_ff <= (mains_c != '0) ? CW'(1) : '0;
            span_ff    <= 1'b0;
         end else begin
            if (cmd.join_root && cmd.forest == FOREST_MAIN && join_size > largest_ff) begin
               largest_ff <= join_size;
            end
            if (cmd.mark_span && ra_ff == rb_ff) begin
               span_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_rsp) begin
         lc_ff <= largest_ff[COUNT_W-1:0];
         sp_ff <= span_ff;
      end
   end

   assign largest_cluster = lc_ff;
   assign spanning        = sp_ff;

   always_comb begin
      stat.clr_last   = (clr_ff == LAST_IDX);
      stat.is_restart = (item_cmd_ff == CMD_RESTART);
      stat.edge_ok    = (u_ext < total_c) && (v_ext < total_c);
      stat.span_go    = span_on && !span_ff;
      stat.main_ok    = (u_ext < mains_c) && (v_ext < mains_c);
      stat.root_found = rdata[EW-1];
      stat.roots_eq   = (ra_ff == rb_ff);
   end

endmodule

`default_nettype wire

/* rtl/core/bpuf_ctrl.sv */
// Sequencing state machine of the union-find unit: root walks, joins, clears, handshakes.
// Depends on bpuf_pkg and the assertion macro header.
`default_nettype none
`include "bond_percolation_union_find_unit_defines.svh"

module bpuf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output bpuf_pkg::ctrl_cmd_type  cmd,
   input  bpuf_pkg::dp_status_type stat
);
   import bpuf_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECIDE, S_READ, S_CHECK,
      S_CMP, S_JOIN1, S_JOIN2, S_MAIN, S_PUT
   } state_type;

   typedef enum logic [2:0] {
      P_SU, P_SV, P_SA, P_SB, P_MU, P_MV
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      put_ff, put_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      put_in       = put_ff;
      cmd          = '0;
      cmd.forest   = (phase_ff == P_MU || phase_ff == P_MV) ? FOREST_MAIN : FOREST_SPAN;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (stat.clr_last) begin
               state_in = put_ff ? S_PUT : S_IDLE;
               put_in   = 1'b0;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.ld_req = 1'b1;
               state_in   = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.is_restart) begin
               cmd.restart = 1'b1;
               put_in      = 1'b1;
               state_in    = S_CLEAR;
            end else if (!stat.edge_ok) begin
               state_in = S_PUT;
            end else if (stat.span_go) begin
               cmd.ld_node  = 1'b1;
               cmd.node_sel = SEL_U;
               phase_in     = P_SU;
               state_in     = S_READ;
            end else if (stat.main_ok) begin
               cmd.ld_node  = 1'b1;
               cmd.node_sel = SEL_U;
               phase_in     = P_MU;
               state_in     = S_READ;
            end else begin
               state_in = S_PUT;
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!stat.root_found) begin
               cmd.step = 1'b1;
               state_in = S_READ;
            end else begin
               case (phase_ff)
                  P_SU, P_MU: begin
                     cmd.save_a   = 1'b1;
                     cmd.ld_node  = 1'b1;
                     cmd.node_sel = SEL_V;
                     phase_in     = (phase_ff == P_SU) ? P_SV : P_MV;
                     state_in     = S_READ;
                  end
                  P_SA: begin
                     cmd.save_a   = 1'b1;
                     cmd.ld_node  = 1'b1;
                     cmd.node_sel = SEL_B;
                     phase_in     = P_SB;
                     state_in     = S_READ;
                  end
                  default: begin
                     cmd.save_b = 1'b1;
                     state_in   = S_CMP;
                  end
               endcase
            end
         end
         S_CMP: begin
            case (phase_ff)
               P_SV:    state_in = stat.roots_eq ? S_MAIN : S_JOIN1;
               P_SB: begin
                  cmd.mark_span = 1'b1;
                  state_in      = S_MAIN;
               end
               P_MV:    state_in = stat.roots_eq ? S_PUT : S_JOIN1;
               default: state_in = S_PUT;
            endcase
         end
         S_JOIN1: begin
            cmd.join_root = 1'b1;
            state_in      = S_JOIN2;
         end
         S_JOIN2: begin
            cmd.join_link = 1'b1;
            if (phase_ff == P_MV) begin
               state_in = S_PUT;
            end else begin
               cmd.ld_node  = 1'b1;
               cmd.node_sel = SEL_A;
               phase_in     = P_SA;
               state_in     = S_READ;
            end
         end
         S_MAIN: begin
            if (stat.main_ok) begin
               cmd.ld_node  = 1'b1;
               cmd.node_sel = SEL_U;
               phase_in     = P_MU;
               state_in     = S_READ;
            end else begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.ld_rsp   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      req_ready_in = (state_in == S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         phase_ff     <= P_SU;
         put_ff       <= 1'b0;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         put_ff       <= put_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   `BPUF_ASSERT_NEXT(a_put_fills_output, (state_ff == S_PUT && !rsp_valid_ff), rsp_valid_ff, "result not loaded from put state")
   `BPUF_ASSERT_NOW(a_no_take_in_clear, (state_ff == S_CLEAR), !req_ready_ff, "request taken during clear")
   `BPUF_ASSERT_NOW(a_join_distinct, (state_ff == S_JOIN1), !stat.roots_eq, "join of a root with itself")

endmodule

`default_nettype wire

/* rtl/core/bond_percolation_union_find_unit.sv */
// Union-find bond percolation unit: top level joining controller and datapath.
// Edge words walk to both roots and join them by size, spanning forest before main forest.
// One word at a time; the request side is ready again from the cycle after the response
// loads. A restart word is answered after a sweep that clears one entry of both forests
// per cycle. After reset a clearing pass over every forest entry runs with the request
// side not ready.
`default_nettype none

module bond_percolation_union_find_unit #(
   parameter int MAX_NODES = bpuf_pkg::DEF_MAX_NODES
) (
   input logic        clock,
   input logic        reset,
   bpuf_req_if.sink   req_ch,
   bpuf_rsp_if.source rsp_ch,
   bpuf_csr_if.sink   csr_ch
);
   import bpuf_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type stat;

   // The block takes register writes unchecked; users must issue them only while the unit is idle.
   assign csr_ch.ready = 1'b1;

   // The controller sequences every word: it walks the forests that apply to their roots,
   // joins roots by size and holds the result until the response side takes it.
   bpuf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // The datapath holds both forests in memory, the configuration registers,
   // the largest-cluster and spanning flags and the output word.
   bpuf_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_we          (csr_ch.valid),
      .csr_addr        (csr_ch.addr),
      .csr_data        (csr_ch.data),
      .req_cmd         (req_ch.cmd),
      .req_node_u      (req_ch.node_u),
      .req_node_v      (req_ch.node_v),
      .largest_cluster (rsp_ch.largest_cluster),
      .spanning        (rsp_ch.spanning)
   );

endmodule

`default_nettype wire

/* tb/bpuf_checker.sv */
// Checker for the union-find unit: watches request, response and register channels.
// Predicts each response from its own copy of both forests; depends on bpuf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpuf_checker (
   input  wire logic clock,
   input  wire logic reset,
   bpuf_req_if       req_mon,
   bpuf_rsp_if       rsp_mon,
   bpuf_csr_if       csr_mon,
   output int        fail_count,
   output int        pending_count
);
   import bpuf_pkg::*;

   localparam int NODES = DEF_MAX_NODES;

   typedef struct packed {
      logic [COUNT_W-1:0] largest_cluster;
      logic               spanning;
   } cluster_word_type;

   int main_count_reg, total_count_reg, bound_a_reg, bound_b_reg;
   int main_parent[NODES];
   int span_parent[NODES];
   int largest_size;
   bit span_latched;
   cluster_word_type expected_words[$];

   function automatic int clamp_nodes(int n);
      return (n > NODES) ? NODES : n;
   endfunction

   function automatic int find_main(int node);
      int steps;
      steps = 0;
      while (main_parent[node] >= 0 && steps < NODES) begin
         node = main_parent[node];
         steps++;
      end
      return node;
   endfunction

   function automatic int find_span(int node);
      int steps;
      steps = 0;
      while (span_parent[node] >= 0 && steps < NODES) begin
         node = span_parent[node];
         steps++;
      end
      return node;
   endfunction

   function automatic void wipe_forests();
      for (int i = 0; i < NODES; i++) begin
         main_parent[i] = -1;
         span_parent[i] = -1;
      end
      largest_size = (clamp_nodes(main_count_reg) > 0) ? 1 : 0;
      span_latched = 1'b0;
   endfunction

   function automatic cluster_word_type apply_edge(logic cmd, int u, int v);
      int mains, total, ra, rb;
      cluster_word_type w;
      mains = clamp_nodes(main_count_reg);
      total = clamp_nodes(total_count_reg);
      if (cmd == CMD_RESTART) begin
         wipe_forests();
      end else if (u < total && v < total) begin
         if (!span_latched && bound_a_reg >= 0 && bound_b_reg >= 0 &&
             bound_a_reg < total && bound_b_reg < total) begin
            ra = find_span(u);
            rb = find_span(v);
            if (ra != rb) begin
               // Union by size; ties keep the first root.
               if (span_parent[ra] > span_parent[rb]) begin
                  span_parent[rb] += span_parent[ra];
                  span_parent[ra] = rb;
               end else begin
                  span_parent[ra] += span_parent[rb];
                  span_parent[rb] = ra;
               end
               if (find_span(bound_a_reg) == find_span(bound_b_reg)) span_latched = 1'b1;
            end
         end
         if (u < mains && v < mains) begin
            ra = find_main(u);
            rb = find_main(v);
            if (ra != rb) begin
               if (main_parent[ra] > main_parent[rb]) begin
                  main_parent[rb] += main_parent[ra];
                  main_parent[ra] = rb;
                  if (-main_parent[rb] > largest_size) largest_size = -main_parent[rb];
               end else begin
                  main_parent[ra] += main_parent[rb];
                  main_parent[rb] = ra;
                  if (-main_parent[ra] > largest_size) largest_size = -main_parent[ra];
               end
            end
         end
      end
      w.largest_cluster = largest_size[COUNT_W-1:0];
      w.spanning        = span_latched;
      return w;
   endfunction

   always @(posedge clock) begin
      cluster_word_type want;
      if (reset) begin
         main_count_reg  = 0;
         total_count_reg = 0;
         bound_a_reg     = -1;
         bound_b_reg     = -1;
         wipe_forests();
         expected_words.delete();
         fail_count = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (reg_index_type'(csr_mon.addr))
               REG_MAIN_COUNT:  main_count_reg = int'(csr_mon.data);
               REG_TOTAL_COUNT: total_count_reg = int'(csr_mon.data);
               REG_BOUNDARY_A:  bound_a_reg = int'($signed(csr_mon.data));
               REG_BOUNDARY_B:  bound_b_reg = int'($signed(csr_mon.data));
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            expected_words.push_back(apply_edge(req_mon.cmd, int'(req_mon.node_u),
                                                int'(req_mon.node_v)));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected response word: largest_cluster %0d spanning %0d",
                      rsp_mon.largest_cluster, rsp_mon.spanning);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_mon.largest_cluster !== want.largest_cluster) begin
                  $error("largest_cluster: expected %0d actual %0d",
                         want.largest_cluster, rsp_mon.largest_cluster);
                  fail_count++;
               end
               if (rsp_mon.spanning !== want.spanning) begin
                  $error("spanning: expected %0d actual %0d",
                         want.spanning, rsp_mon.spanning);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_words.size();
   end
endmodule

`default_nettype wire

/* tb/tb_bond_percolation_union_find_unit.sv */
// Top of the union-find unit testbench: clock, reset, stimulus and verdict.
// Depends on bpuf_pkg, the channel interfaces and bpuf_checker.
`timescale 1ns / 1ps
`default_nettype none

module tb_bond_percolation_union_find_unit;
   import bpuf_pkg::*;

   // No edge may stall longer than this without some channel moving a word;
   // a restart sweep and the clearing pass both fit within it.
   localparam int STALL_LIMIT = 20000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   idle_cycles;
   bit   rsp_calm;

   bpuf_req_if req_ch ();
   bpuf_rsp_if rsp_ch ();
   bpuf_csr_if csr_ch ();

   bond_percolation_union_find_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   bpuf_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_mon       (csr_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The response side stalls in random bursts unless the run is in its calm tail.
   initial begin
      int burst;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!rsp_calm && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 19);
            rsp_ch.ready <= 1'b0;
            repeat (burst) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   // The watchdog counts cycles in which no channel accepts a word.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_bond_percolation_union_find_unit failed");
         $finish;
      end
   end

   // Writes one register; the handshake completes at the edge where ready is seen.
   task automatic write_reg(reg_index_type idx, logic [COUNT_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.addr  <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   // Sends one request word; an optional idle burst comes first.
   task automatic send_word(logic cmd, logic [NODE_W-1:0] u, logic [NODE_W-1:0] v,
                            bit allow_gap);
      if (allow_gap && $urandom_range(0, 6) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.cmd    <= cmd;
      req_ch.node_u <= u;
      req_ch.node_v <= v;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Idle the sender until every expected word has arrived.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_lattice(int mains, int total, int ba, int bb);
      write_reg(REG_MAIN_COUNT, mains[COUNT_W-1:0]);
      write_reg(REG_TOTAL_COUNT, total[COUNT_W-1:0]);
      write_reg(REG_BOUNDARY_A, ba[COUNT_W-1:0]);
      write_reg(REG_BOUNDARY_B, bb[COUNT_W-1:0]);
   endtask

   // Random edges: mostly inside the span lattice, a few far out of range,
   // and an occasional restart so that clusters keep growing from scratch.
   task automatic random_phase(int count, int total, bit gaps);
      int span;
      int pick;
      span = (total > 0) ? total : 1;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 2)
            send_word(CMD_RESTART, NODE_W'($urandom), NODE_W'($urandom), gaps);
         else if (pick < 8)
            send_word(~CMD_RESTART, NODE_W'($urandom), NODE_W'($urandom), gaps);
         else
            send_word(~CMD_RESTART, NODE_W'($urandom_range(0, span - 1)),
                      NODE_W'($urandom_range(0, span - 1)), gaps);
      end
   endtask

   initial begin
      rsp_calm     = 1'b0;
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.cmd   = CMD_RESTART;
      req_ch.node_u = '0;
      req_ch.node_v = '0;
      csr_ch.valid = 1'b0;
      csr_ch.addr  = REG_MAIN_COUNT;
      csr_ch.data  = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part. With reset counts every edge is out of range.
      send_word(~CMD_RESTART, '0, '0, 1'b0);
      drain();
      // Small lattice: nodes 0..7 main, 8 and 9 are the boundaries.
      set_lattice(8, 10, 8, 9);
      send_word(CMD_RESTART, '0, '0, 1'b0);
      send_word(~CMD_RESTART, 10'd0, 10'd1, 1'b0);
      send_word(~CMD_RESTART, 10'd1, 10'd0, 1'b0);  // already joined
      send_word(~CMD_RESTART, 10'd3, 10'd3, 1'b0);  // self loop
      send_word(~CMD_RESTART, 10'd8, 10'd0, 1'b0);  // boundary edge, span only
      send_word(~CMD_RESTART, 10'd10, 10'd1, 1'b0); // endpoint out of range
      send_word(~CMD_RESTART, 10'd1023, 10'd1023, 1'b0);
      send_word(~CMD_RESTART, 10'd2, 10'd3, 1'b0);
      send_word(~CMD_RESTART, 10'd1, 10'd3, 1'b0);
      send_word(~CMD_RESTART, 10'd9, 10'd2, 1'b0);  // spanning latches here
      send_word(~CMD_RESTART, 10'd4, 10'd5, 1'b0);
      drain();
      // Counts above the maximum clamp; boundaries at the top and bottom nodes.
      set_lattice(2047, 2047, 1023, 0);
      send_word(~CMD_RESTART, 10'd1023, 10'd0, 1'b0);
      send_word(~CMD_RESTART, 10'd1023, 10'd512, 1'b0);
      send_word(CMD_RESTART, 10'h3ff, 10'h3ff, 1'b0);
      send_word(~CMD_RESTART, 10'h2aa, 10'h155, 1'b0);
      drain();
      // Boundary negative: spanning off; boundary beyond total: also off.
      set_lattice(0, 6, -1, 2);
      send_word(~CMD_RESTART, 10'd0, 10'd2, 1'b0);
      drain();
      write_reg(REG_BOUNDARY_A, 11'd600);
      send_word(~CMD_RESTART, 10'd0, 10'd1, 1'b0);
      send_word(CMD_RESTART, 10'd0, 10'd0, 1'b0);
      drain();

      // Random phases over a spread of lattice shapes.
      set_lattice(16, 18, 16, 17);
      send_word(CMD_RESTART, '0, '0, 1'b0);
      random_phase(250, 18, 1'b1);
      drain();  // the sender waits for every expected word here
      set_lattice(50, 52, 50, 51);
      send_word(CMD_RESTART, '0, '0, 1'b0);
      random_phase(250, 52, 1'b1);
      drain();
      // Boundary a inside the main range, b outside it; main count below total.
      set_lattice(30, 64, 3, 60);
      random_phase(200, 64, 1'b1);
      drain();
      set_lattice(1024, 1024, 0, 1023);
      send_word(CMD_RESTART, '0, '0, 1'b0);
      random_phase(250, 1024, 1'b1);
      drain();
      // Calm tail: no idling on either side.
      set_lattice(12, 14, 12, 13);
      send_word(CMD_RESTART, '0, '0, 1'b0);
      rsp_calm = 1'b1;
      random_phase(150, 14, 1'b0);
      drain();

      if (fail_count == 0)
         $display("tb_bond_percolation_union_find_unit passed");
      else
         $display("tb_bond_percolation_union_find_unit failed");
      $finish;
   end
endmodule

`default_nettype wire
